### hw/rtl/fus_pkg.sv
// Shared types, constants and register map of the firmware upload sequencer.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package fus_pkg;

    // Sequencing constants
    localparam int CHUNK_BYTES         = 192;
    localparam int RETRY_LIMIT         = 5;
    localparam int ACK_TIMEOUT_TICKS   = 350;
    localparam int START_TIMEOUT_TICKS = 500;
    localparam int BOOT_OFFSET_BASE    = 1024 * 2 * 50;
    localparam int APP_OFFSET_BASE     = 8;

    // Field widths
    localparam int SIZE_W    = 20;
    localparam int CRC_W     = 16;
    localparam int ID_W      = 8;
    localparam int PTR_W     = 21;
    localparam int OFFSET_W  = 22;
    localparam int RETRY_W   = 3;
    localparam int TIMER_W   = 9;
    localparam int STATUS_W  = 4;
    localparam int ACK_W     = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_ACK    = 2'd2,
        OP_CANCEL = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_ERASE = 2'd0,
        PH_CRC   = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ERASE    = 4'd0,
        ST_CRC      = 4'd1,
        ST_DATA     = 4'd2,
        ST_ERASE_TO = 4'd3,
        ST_CRC_TO   = 4'd4,
        ST_DATA_TO  = 4'd5,
        ST_DONE     = 4'd6,
        ST_CANCEL   = 4'd7,
        ST_IDLE     = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PKT_ERASE = 2'd0,
        PKT_CRC   = 2'd1,
        PKT_DATA  = 2'd2,
        PKT_JUMP  = 2'd3
    } pkt_kind_t;

    // Which packet one event sends
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_ERASE = 3'd1,
        ACT_CRC   = 3'd2,
        ACT_DATA  = 3'd3,
        ACT_JUMP  = 3'd4
    } pkt_act_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_SIZE      = 3'd0,
        REG_IMAGE_CRC       = 3'd1,
        REG_BOOTLOADER_MODE = 3'd2,
        REG_FORWARD_TO_CAN  = 3'd3,
        REG_CAN_ID          = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_size;
        logic [CRC_W-1:0]  image_crc;
        logic              bootloader_mode;
        logic              forward_to_can;
        logic [ID_W-1:0]   can_id;
    } cfg_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [ACK_W-1:0] ack_status;
    } in_word_t;

    typedef struct packed {
        logic                packet_valid;
        logic [1:0]          packet_kind;
        logic                forward_can;
        logic [ID_W-1:0]     forward_id;
        logic [OFFSET_W-1:0] packet_offset;
        logic [SIZE_W-1:0]   packet_length;
        logic [CRC_W-1:0]    packet_crc;
        logic                uploading;
        logic [STATUS_W-1:0] status;
        logic [PTR_W-1:0]    progress_bytes;
    } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/fus_cfg_regs.sv
// APB configuration register file of the firmware upload sequencer.
// Depends on fus_pkg for the register map and the cfg_t bundle.
`default_nettype none

module fus_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fus_pkg::APB_AW-1:0]  paddr,
    input  wire logic [fus_pkg::APB_DW-1:0]  pwdata,
    output logic      [fus_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output fus_pkg::cfg_t                    cfg
);

    fus_pkg::cfg_t    cfg_reg;
    fus_pkg::cfg_t    cfg_next;
    fus_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = fus_pkg::reg_idx_t'(paddr[fus_pkg::APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                fus_pkg::REG_IMAGE_SIZE:
                    cfg_next.image_size = pwdata[fus_pkg::SIZE_W-1:0];
                fus_pkg::REG_IMAGE_CRC:
                    cfg_next.image_crc = pwdata[fus_pkg::CRC_W-1:0];
                fus_pkg::REG_BOOTLOADER_MODE:
                    cfg_next.bootloader_mode = pwdata[0];
                fus_pkg::REG_FORWARD_TO_CAN:
                    cfg_next.forward_to_can = pwdata[0];
                fus_pkg::REG_CAN_ID:
                    cfg_next.can_id = pwdata[fus_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fus_pkg::REG_IMAGE_SIZE:
                prdata = fus_pkg::APB_DW'(cfg_reg.image_size);
            fus_pkg::REG_IMAGE_CRC:
                prdata = fus_pkg::APB_DW'(cfg_reg.image_crc);
            fus_pkg::REG_BOOTLOADER_MODE:
                prdata = fus_pkg::APB_DW'(cfg_reg.bootloader_mode);
            fus_pkg::REG_FORWARD_TO_CAN:
                prdata = fus_pkg::APB_DW'(cfg_reg.forward_to_can);
            fus_pkg::REG_CAN_ID:
                prdata = fus_pkg::APB_DW'(cfg_reg.can_id);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fus_seq.sv
// Upload sequencer state and per-event logic: phase, retries, tick timer,
// byte pointer and status, plus the packet descriptor of each event. Uses fus_pkg.
`default_nettype none

module fus_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire fus_pkg::in_word_t evt,
    input  wire fus_pkg::cfg_t     cfg,
    output fus_pkg::out_word_t     result
);

    localparam logic [fus_pkg::RETRY_W-1:0] RetryFull =
        fus_pkg::RETRY_W'(fus_pkg::RETRY_LIMIT);
    localparam logic [fus_pkg::RETRY_W-1:0] RetryFirst =
        fus_pkg::RETRY_W'(fus_pkg::RETRY_LIMIT - 1);
    localparam logic [fus_pkg::TIMER_W-1:0] AckTicks =
        fus_pkg::TIMER_W'(fus_pkg::ACK_TIMEOUT_TICKS);
    localparam logic [fus_pkg::TIMER_W-1:0] StartTicks =
        fus_pkg::TIMER_W'(fus_pkg::START_TIMEOUT_TICKS);
    localparam logic [fus_pkg::PTR_W-1:0] ChunkStep =
        fus_pkg::PTR_W'(fus_pkg::CHUNK_BYTES);
    localparam logic [fus_pkg::SIZE_W:0] ChunkLen =
        (fus_pkg::SIZE_W + 1)'(fus_pkg::CHUNK_BYTES);

    logic                            active_reg,  active_next;
    fus_pkg::phase_t                 phase_reg,   phase_next;
    logic [fus_pkg::RETRY_W-1:0]     retries_reg, retries_next;
    logic [fus_pkg::TIMER_W-1:0]     timer_reg,   timer_next;
    logic [fus_pkg::PTR_W-1:0]       ptr_reg,     ptr_next;
    fus_pkg::status_t                status_reg,  status_next;
    logic                            boot_reg,    boot_next;
    fus_pkg::pkt_act_t               act;

    logic                            do_update;
    logic                            failed;
    logic [fus_pkg::PTR_W-1:0]       ptr_inc;
    logic [fus_pkg::SIZE_W:0]        size_ext;
    logic [fus_pkg::SIZE_W:0]        bytes_left;
    logic [fus_pkg::OFFSET_W-1:0]    data_base;

    assign ptr_inc  = ptr_reg + ChunkStep;
    assign size_ext = {1'b0, cfg.image_size};

    // Next-state logic: one event, applied in order like the upload protocol.
    always_comb begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        retries_next = retries_reg;
        timer_next   = timer_reg;
        ptr_next     = ptr_reg;
        status_next  = status_reg;
        boot_next    = boot_reg;
        act          = fus_pkg::ACT_NONE;
        do_update    = 1'b0;
        failed       = 1'b0;

        case (evt.opcode)
            fus_pkg::OP_START: begin
                boot_next   = cfg.bootloader_mode;
                active_next = 1'b1;
                ptr_next    = '0;
                if (cfg.bootloader_mode) begin
                    // Skip erase and CRC; first data chunk goes out at once
                    phase_next   = fus_pkg::PH_DATA;
                    retries_next = RetryFirst;
                    timer_next   = AckTicks;
                    status_next  = fus_pkg::ST_DATA;
                    act          = fus_pkg::ACT_DATA;
                end else begin
                    phase_next   = fus_pkg::PH_ERASE;
                    retries_next = RetryFull;
                    timer_next   = StartTicks;
                    status_next  = fus_pkg::ST_ERASE;
                    act          = fus_pkg::ACT_ERASE;
                end
            end
            fus_pkg::OP_TICK: begin
                if (active_reg) begin
                    if (timer_reg != '0) begin
                        timer_next = timer_reg - 1'b1;
                    end else begin
                        do_update = 1'b1;
                        failed    = 1'b1;
                    end
                end
            end
            fus_pkg::OP_ACK: begin
                do_update = active_reg;
                failed    = (evt.ack_status == '0);
            end
            fus_pkg::OP_CANCEL: begin
                if (active_reg) begin
                    active_next = 1'b0;
                    ptr_next    = '0;
                    phase_next  = fus_pkg::PH_ERASE;
                    status_next = fus_pkg::ST_CANCEL;
                end
            end
            default: ;
        endcase

        if (do_update) begin
            case (phase_reg)
                fus_pkg::PH_ERASE: begin
                    if (failed) begin
                        // Erase gets no resend
                        active_next = 1'b0;
                        ptr_next    = '0;
                        status_next = fus_pkg::ST_ERASE_TO;
                    end else begin
                        phase_next   = fus_pkg::PH_CRC;
                        retries_next = RetryFirst;
                        timer_next   = AckTicks;
                        status_next  = fus_pkg::ST_CRC;
                        act          = fus_pkg::ACT_CRC;
                    end
                end
                fus_pkg::PH_CRC: begin
                    if (!failed) begin
                        phase_next   = fus_pkg::PH_DATA;
                        retries_next = RetryFirst;
                        timer_next   = AckTicks;
                        status_next  = fus_pkg::ST_DATA;
                        act          = fus_pkg::ACT_DATA;
                    end else if (retries_reg != '0) begin
                        retries_next = retries_reg - 1'b1;
                        timer_next   = AckTicks;
                        status_next  = fus_pkg::ST_CRC;
                        act          = fus_pkg::ACT_CRC;
                    end else begin
                        active_next = 1'b0;
                        ptr_next    = '0;
                        phase_next  = fus_pkg::PH_ERASE;
                        status_next = fus_pkg::ST_CRC_TO;
                    end
                end
                fus_pkg::PH_DATA: begin
                    if (!failed) begin
                        timer_next = AckTicks;
                        if ({1'b0, ptr_inc} >= {1'b0, size_ext}) begin
                            // Last chunk acknowledged
                            retries_next = RetryFull;
                            active_next  = 1'b0;
                            ptr_next     = '0;
                            phase_next   = fus_pkg::PH_ERASE;
                            status_next  = fus_pkg::ST_DONE;
                            if (!boot_reg) begin
                                act = fus_pkg::ACT_JUMP;
                            end
                        end else begin
                            ptr_next     = ptr_inc;
                            retries_next = RetryFirst;
                            status_next  = fus_pkg::ST_DATA;
                            act          = fus_pkg::ACT_DATA;
                        end
                    end else if (retries_reg != '0) begin
                        retries_next = retries_reg - 1'b1;
                        timer_next   = AckTicks;
                        status_next  = fus_pkg::ST_DATA;
                        act          = fus_pkg::ACT_DATA;
                    end else begin
                        active_next = 1'b0;
                        ptr_next    = '0;
                        phase_next  = fus_pkg::PH_ERASE;
                        status_next = fus_pkg::ST_DATA_TO;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output logic: packet descriptor built from the chosen action.
    always_comb begin
        bytes_left = ({1'b0, ptr_next} < {1'b0, size_ext}) ?
                     (size_ext - ptr_next[fus_pkg::SIZE_W:0]) : '0;
        data_base  = boot_next ? fus_pkg::OFFSET_W'(fus_pkg::BOOT_OFFSET_BASE)
                               : fus_pkg::OFFSET_W'(fus_pkg::APP_OFFSET_BASE);

        result                = '0;
        result.uploading      = active_next;
        result.status         = status_next;
        result.progress_bytes = ptr_next;

        case (act)
            fus_pkg::ACT_ERASE: begin
                result.packet_valid  = 1'b1;
                result.packet_kind   = fus_pkg::PKT_ERASE;
                result.packet_length = cfg.image_size;
            end
            fus_pkg::ACT_CRC: begin
                result.packet_valid  = 1'b1;
                result.packet_kind   = fus_pkg::PKT_CRC;
                result.packet_length = cfg.image_size;
                result.packet_crc    = cfg.image_crc;
            end
            fus_pkg::ACT_DATA: begin
                result.packet_valid  = 1'b1;
                result.packet_kind   = fus_pkg::PKT_DATA;
                result.packet_offset = {1'b0, ptr_next} + data_base;
                result.packet_length = (bytes_left > ChunkLen) ?
                                       ChunkLen[fus_pkg::SIZE_W-1:0] :
                                       bytes_left[fus_pkg::SIZE_W-1:0];
            end
            fus_pkg::ACT_JUMP: begin
                result.packet_valid = 1'b1;
                result.packet_kind  = fus_pkg::PKT_JUMP;
            end
            default: ;
        endcase

        if (result.packet_valid && cfg.forward_to_can) begin
            result.forward_can = 1'b1;
            result.forward_id  = cfg.can_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            phase_reg   <= fus_pkg::PH_ERASE;
            retries_reg <= '0;
            timer_reg   <= '0;
            ptr_reg     <= '0;
            status_reg  <= fus_pkg::ST_IDLE;
            boot_reg    <= 1'b0;
        end else if (step_en) begin
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            retries_reg <= retries_next;
            timer_reg   <= timer_next;
            ptr_reg     <= ptr_next;
            status_reg  <= status_next;
            boot_reg    <= boot_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/firmware_upload_sequencer.sv
// Top level of the firmware upload sequencer: event input register, result
// register and APB port. Instantiates fus_cfg_regs and fus_seq; uses fus_pkg.
//
// Usage:
//   Program image_size, image_crc, bootloader_mode, forward_to_can and can_id
//   over APB (byte addresses 0x00..0x10) while no event is in flight, then feed
//   events (start, tick, acknowledge, cancel) on the s_ channel. Every event
//   yields exactly one word on the m_ channel: an optional packet descriptor
//   (kind, offset, length, CRC, CAN forward prefix) plus uploading flag,
//   status and byte pointer after the event.
// Pipeline and throughput:
//   An accepted event passes the input register, then the result register,
//   before it shows up on m_. One event per cycle is sustained while m_ready
//   is high: the sequencer state updates in the same cycle the event moves
//   into the result register, so the next event sees it immediately.
// Stalls:
//   When m_ready is low the result word holds; the input register still takes
//   one more event, then s_ready drops until the result is taken.
// Reset:
//   aresetn low (synchronous) empties both registers, clears configuration to
//   zero and returns the sequencer to idle (status 8, no upload running).
`default_nettype none

module firmware_upload_sequencer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Event channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire fus_pkg::in_word_t           s_data,
    // Result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output fus_pkg::out_word_t               m_data,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fus_pkg::APB_AW-1:0]  paddr,
    input  wire logic [fus_pkg::APB_DW-1:0]  pwdata,
    output logic      [fus_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    fus_pkg::cfg_t      cfg;
    fus_pkg::in_word_t  in_data_reg;
    logic               in_valid_reg;
    fus_pkg::out_word_t out_data_reg;
    logic               out_valid_reg;
    fus_pkg::out_word_t step_result;
    logic               advance;

    // Move the held event into the result register when that slot is free
    // or being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    fus_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fus_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .evt     (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register: hold an event until it can advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register: load on advance, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fus_checker.sv
// Port-level checks of the firmware upload sequencer, bound to the top level.
// Depends on fus_pkg and firmware_upload_sequencer.
`default_nettype none

module fus_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire fus_pkg::out_word_t m_data
);

    // A stalled result word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A word without a packet carries an all-zero descriptor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.packet_valid |->
            m_data.packet_kind == '0 && !m_data.forward_can &&
            m_data.forward_id == '0 && m_data.packet_offset == '0 &&
            m_data.packet_length == '0 && m_data.packet_crc == '0)
        else $error("descriptor fields set without a packet");

    // No upload running means the byte pointer is back at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.uploading |-> m_data.progress_bytes == '0)
        else $error("byte pointer not cleared when idle");

    // Data chunks never exceed the chunk size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.packet_valid && m_data.packet_kind == fus_pkg::PKT_DATA |->
            m_data.packet_length <= fus_pkg::SIZE_W'(fus_pkg::CHUNK_BYTES))
        else $error("data chunk longer than chunk size");

endmodule

bind firmware_upload_sequencer fus_checker u_fus_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
